// ----- sv/m4alu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package m4alu_pkg;
	typedef enum logic [1:0] {
		KIND_LOAD_HELD = 2'd0,
		KIND_LOAD_OPND = 2'd1,
		KIND_RUN       = 2'd2,
		KIND_NONE      = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		OP_ADDMAT  = 3'd0,
		OP_ADDSCAL = 3'd1,
		OP_SUBMAT  = 3'd2,
		OP_SUBSCAL = 3'd3,
		OP_MATMUL  = 3'd4,
		OP_MULSCAL = 3'd5,
		OP_DIVMAT  = 3'd6,
		OP_DIVSCAL = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CALC,
		ST_DIV,
		ST_EMIT,
		ST_CMP
	} state_t;

	// control from sequencer to the divider
	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	// divider status back to the sequencer
	typedef struct packed {
		logic        done;
		logic [31:0] quot;
		logic        ovf;
		logic        dz;
	} div_rsp_t;

	localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
	localparam logic signed [63:0] Q_MIN = -64'sd2147483648;
endpackage
`default_nettype wire

// ----- sv/m4alu_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module m4alu_div #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire m4alu_pkg::div_req_t req,
	output m4alu_pkg::div_rsp_t     rsp
);
	import m4alu_pkg::*;

	localparam int NW = 32 + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [31:0]   den_q;
	logic [NW:0]   rem_q;
	logic          neg_q;
	logic          zero_q;
	logic          dz_q;
	logic          done_q;
	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [NW:0]   trial;
	logic [NW-1:0] qmag;
	logic signed [NW:0] qs;
	logic [31:0]   quot;
	logic          ovf;

	assign trial = {rem_q[NW-1:0], num_q[NW-1]} - {{(NW-31){1'b0}}, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division on magnitudes, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= {(req.dividend[31] ? 32'(-req.dividend) : req.dividend),
				{FRAC_BITS{1'b0}}};
			den_q <= req.divisor[31] ? 32'(-req.divisor) : req.divisor;
			rem_q <= '0;
			neg_q <= req.dividend[31] ^ req.divisor[31];
			zero_q <= (req.dividend == 32'd0);
			dz_q <= (req.divisor == 32'd0);
		end else if (busy_q) begin
			if (!trial[NW]) begin
				rem_q <= trial;
				num_q <= {num_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[NW-1:0], num_q[NW-1]};
				num_q <= {num_q[NW-2:0], 1'b0};
			end
		end
	end

	assign qmag = num_q;
	assign qs = neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

	always_comb begin
		ovf  = 1'b0;
		quot = qs[31:0];
		if (dz_q) begin
			// divide by zero saturates by the sign of the dividend; a zero dividend gives zero
			if (zero_q) quot = '0;
			else if (neg_q) quot = 32'h8000_0000;
			else quot = 32'h7fff_ffff;
		end else if (qs > $signed(Q_MAX[NW:0])) begin
			ovf = 1'b1;
			quot = 32'h7fff_ffff;
		end else if (qs < $signed(Q_MIN[NW:0])) begin
			ovf = 1'b1;
			quot = 32'h8000_0000;
		end
	end

	assign rsp = '{done: done_q, quot: quot, ovf: ovf, dz: dz_q};
endmodule
`default_nettype wire

// ----- sv/m4alu_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
module m4alu_core #(
	parameter int DIM       = 4,
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [3:0]  elem_index,
	input  wire logic [31:0] value,
	input  wire logic [2:0]  op_code,
	input  wire logic        compare_req,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       out_index,
	output logic [31:0]      out_value,
	output logic             last_flag,
	output logic             equal_flag,
	output logic             div_zero_flag,
	output logic             overflow_flag
);
	import m4alu_pkg::*;

	localparam int NE = DIM * DIM;
	localparam int EW = $clog2(NE);
	localparam int KW = $clog2(DIM);
	localparam int AW = 64 + KW + 1;

	logic [31:0] held_q [NE];
	logic [31:0] opnd_q [NE];
	logic [31:0] row_q [DIM];

	state_t state_q, state_d;
	logic [EW-1:0] e_q;
	logic [KW-1:0] k_q;
	op_t           op_q;
	logic [31:0]   scal_q;
	logic [31:0]   a_q, b_q;
	logic signed [63:0] prod_s1;
	logic signed [AW-1:0] acc_q;
	logic          eq_q;
	logic          cmp_q;
	logic [31:0]   res_q;
	logic          ovf_q, dz_q;
	logic          mul_v_s1;
	div_req_t      dreq;
	div_rsp_t      drsp;

	logic [EW-1:0] ia, ib;
	logic [KW-1:0] row, col;
	logic signed [33:0] sum;
	logic fire_in, fire_out, last_e, last_k;

	assign row = KW'(e_q >> KW);
	assign col = KW'(e_q);
	assign last_e = (e_q == EW'(NE - 1));
	assign last_k = (k_q == KW'(DIM - 1));
	assign fire_in = in_valid && in_ready;
	assign fire_out = out_valid && out_ready;

	always_comb begin
		ia = e_q;
		ib = e_q;
		if (op_q == OP_MATMUL) begin
			ia = EW'({row, k_q});
			ib = EW'({k_q, col});
		end
	end

	m4alu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk, .arst_n, .req(dreq), .rsp(drsp)
	);

	assign dreq = '{start: (state_q == ST_CALC) &&
		(op_q == OP_DIVMAT || op_q == OP_DIVSCAL), dividend: a_q, divisor: b_q};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (fire_in && kind == KIND_RUN)
				state_d = compare_req ? ST_CMP : ST_READ;
			ST_READ: state_d = ST_CALC;
			ST_CALC: begin
				if (op_q == OP_DIVMAT || op_q == OP_DIVSCAL) state_d = ST_DIV;
				else if (op_q == OP_MATMUL) begin
					if (last_k && mul_v_s1) state_d = ST_EMIT;
				end else if (op_q == OP_MULSCAL) begin
					if (mul_v_s1) state_d = ST_EMIT;
				end else state_d = ST_EMIT;
			end
			ST_DIV: if (drsp.done) state_d = ST_EMIT;
			ST_EMIT: if (fire_out) state_d = (last_e || cmp_q) ? ST_IDLE : ST_READ;
			ST_CMP: if (last_e) state_d = ST_EMIT;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		out_valid = (state_q == ST_EMIT);
	end

	assign out_index = cmp_q ? 4'd0 : 4'(e_q);
	assign out_value = cmp_q ? 32'd0 : res_q;
	assign last_flag = cmp_q || last_e;
	assign equal_flag = cmp_q && eq_q;
	assign div_zero_flag = !cmp_q && dz_q;
	assign overflow_flag = !cmp_q && ovf_q;

	always_comb begin
		sum = '0;
		unique case (op_q)
			OP_ADDMAT, OP_ADDSCAL: sum = 34'($signed(a_q)) + 34'($signed(b_q));
			default: sum = 34'($signed(a_q)) - 34'($signed(b_q));
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			e_q <= '0;
			k_q <= '0;
			mul_v_s1 <= 1'b0;
			cmp_q <= 1'b0;
			for (int i = 0; i < NE; i++) begin
				held_q[i] <= '0;
				opnd_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			mul_v_s1 <= 1'b0;
			if (state_q == ST_IDLE && fire_in) begin
				e_q <= '0;
				k_q <= '0;
				cmp_q <= compare_req && kind == KIND_RUN;
				if (kind == KIND_LOAD_HELD && 32'(elem_index) < 32'(NE))
					held_q[EW'(elem_index)] <= value;
				if (kind == KIND_LOAD_OPND && 32'(elem_index) < 32'(NE))
					opnd_q[EW'(elem_index)] <= value;
			end
			if (state_q == ST_CALC && (op_q == OP_MATMUL || op_q == OP_MULSCAL)
					&& !mul_v_s1)
				mul_v_s1 <= 1'b1;
			if (state_q == ST_CALC && op_q == OP_MATMUL && mul_v_s1 && !last_k)
				k_q <= k_q + 1'b1;
			if (state_q == ST_CMP && !last_e) e_q <= e_q + 1'b1;
			if (state_q == ST_CMP && last_e) e_q <= '0;
			if (state_q == ST_EMIT && fire_out) begin
				// the matrix product still reads this row, so write it back once complete
				if (!cmp_q && col == KW'(DIM - 1))
					for (int c = 0; c < DIM; c++)
						held_q[EW'({row, KW'(c)})] <= (KW'(c) == col) ? res_q : row_q[c];
				e_q <= e_q + 1'b1;
				k_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && fire_in) begin
			op_q <= op_t'(op_code);
			scal_q <= value;
			eq_q <= 1'b1;
			acc_q <= '0;
		end
		if (state_q == ST_EMIT && fire_out && !cmp_q) row_q[col] <= res_q;
		if (state_q == ST_CMP && held_q[e_q] != opnd_q[e_q]) eq_q <= 1'b0;
		if (state_q == ST_READ) begin
			a_q <= held_q[ia];
			b_q <= (op_q == OP_ADDSCAL || op_q == OP_SUBSCAL || op_q == OP_MULSCAL
				|| op_q == OP_DIVSCAL) ? scal_q : opnd_q[ib];
			acc_q <= '0;
		end
		if (state_q == ST_CALC && op_q == OP_MATMUL && mul_v_s1 && !last_k) begin
			a_q <= held_q[EW'({row, KW'(k_q + 1'b1)})];
			b_q <= opnd_q[EW'({KW'(k_q + 1'b1), col})];
		end
		prod_s1 <= $signed(a_q) * $signed(b_q);
		if (mul_v_s1) acc_q <= acc_q + AW'(prod_s1);
		dz_q <= 1'b0;
		ovf_q <= 1'b0;
		if (state_q == ST_CALC) begin
			unique case (op_q)
				OP_ADDMAT, OP_ADDSCAL, OP_SUBMAT, OP_SUBSCAL: begin
					res_q <= sum[31:0];
					if (sum > 34'sd2147483647) begin
						res_q <= 32'h7fff_ffff; ovf_q <= 1'b1;
					end else if (sum < -34'sd2147483648) begin
						res_q <= 32'h8000_0000; ovf_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
		if (state_q == ST_EMIT) begin
			dz_q <= dz_q;
			ovf_q <= ovf_q;
		end
		if (state_q == ST_DIV && drsp.done) begin
			res_q <= drsp.quot;
			dz_q <= drsp.dz;
			ovf_q <= drsp.ovf;
		end
		if (state_q == ST_CALC && state_d == ST_EMIT &&
				(op_q == OP_MATMUL || op_q == OP_MULSCAL)) begin
			// floor of the accumulated exact sum
			automatic logic signed [AW-1:0] t = (acc_q + AW'(prod_s1)) >>> FRAC_BITS;
			res_q <= t[31:0];
			if (t > AW'(Q_MAX)) begin
				res_q <= 32'h7fff_ffff; ovf_q <= 1'b1;
			end else if (t < AW'(Q_MIN)) begin
				res_q <= 32'h8000_0000; ovf_q <= 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ----- sv/matrix4_fixed_point_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
// each element passes read, calculate and emit states; divides add a wait on the
// shared restoring divider, and matrix products accumulate DIM products in calculate
// a run emits DIM*DIM beats, one element in flight; a compare emits a single beat
// loads leave the sequencer idle; not ready while a run or compare is in progress
// arst_n clears both matrices to zero and returns the sequencer to idle
module matrix4_fixed_point_alu #(
	parameter int DIM       = 4,
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // elem_index, value, op_code, compare_req
	input  wire logic [1:0]  s_axis_tuser,  // kind
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // out_index, out_value
	output logic             m_axis_tlast,
	output logic [2:0]       m_axis_tuser   // equal_flag, div_zero_flag, overflow_flag
);
	import m4alu_pkg::*;

	logic [3:0] oi;
	logic [31:0] ov;
	logic eqf, dzf, ovff;

	m4alu_core #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_core (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.kind(s_axis_tuser), .elem_index(s_axis_tdata[3:0]),
		.value(s_axis_tdata[35:4]), .op_code(s_axis_tdata[38:36]),
		.compare_req(s_axis_tdata[39]),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_index(oi), .out_value(ov), .last_flag(m_axis_tlast),
		.equal_flag(eqf), .div_zero_flag(dzf), .overflow_flag(ovff)
	);

	assign m_axis_tdata = {4'd0, ov, oi};
	assign m_axis_tuser = {ovff, dzf, eqf};
endmodule
`default_nettype wire
